[src/lfu_replacement_cache_defines.svh]
// assertion macros used by the lfu replacement cache top level
`ifndef LFU_REPLACEMENT_CACHE_DEFINES_SVH
`define LFU_REPLACEMENT_CACHE_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define LFU_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define LFU_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/lfu_pkg.sv]
// shared types and constants of the lfu replacement cache
package lfu_pkg;

    // configuration register
    localparam int unsigned CFG_W = 5;
    localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

    // beat layout
    localparam int unsigned ADDR_W     = 32;
    localparam int unsigned SLOT_W     = 4;
    localparam int unsigned S_TDATA_W  = 32;
    localparam int unsigned S_TUSER_W  = 1;
    localparam int unsigned M_FIELDS_W = 1 + SLOT_W + 1 + ADDR_W;
    localparam int unsigned M_TDATA_W  = 40;

    // request opcodes
    localparam logic OP_ACCESS = 1'b0;
    localparam logic OP_TOUCH  = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic req_load;   // capture the input beat
        logic lookup;     // tag compare cycle, leaves loaded into the min tree
        logic tree_step;  // one reduction level of the min tree
        logic commit;     // table update and result register load
    } lfu_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic hit;
        logic need_evict;
    } lfu_status_t;

endpackage

[src/lfu_ctrl.sv]
// request sequencer of the lfu replacement cache
module lfu_ctrl #(
    parameter int unsigned LEVELS = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  lfu_pkg::lfu_status_t status,
    output lfu_pkg::lfu_cmd_t    cmd
);
    import lfu_pkg::*;

    localparam int unsigned LVL_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam logic [LVL_W-1:0] LVL_LAST = LVL_W'(LEVELS - 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_LOOKUP = 2'd1;
    localparam logic [1:0] ST_SEARCH = 2'd2;
    localparam logic [1:0] ST_COMMIT = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [LVL_W-1:0] lvl_reg, lvl_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic             out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    // next state and commands
    always_comb begin
        state_next = state_reg;
        lvl_next   = lvl_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.req_load = 1'b1;
                    state_next   = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                cmd.lookup = 1'b1;
                lvl_next   = '0;
                state_next = status.need_evict ? ST_SEARCH : ST_COMMIT;
            end
            ST_SEARCH: begin
                cmd.tree_step = 1'b1;
                if (lvl_reg == LVL_LAST) begin
                    state_next = ST_COMMIT;
                end else begin
                    lvl_next = lvl_reg + 1'b1;
                end
            end
            ST_COMMIT: begin
                if (out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result beat valid
    always_comb begin
        if (cmd.commit) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            lvl_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            lvl_reg      <= lvl_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

[src/lfu_datapath.sv]
// tag table, use counts, recency ranks and victim search of the lfu cache
module lfu_datapath #(
    parameter int unsigned CAPACITY     = 16,
    parameter int unsigned ADDRESS_BITS = 32,
    parameter int unsigned COUNT_BITS   = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [lfu_pkg::CFG_W-1:0]       cfg_wr_data,
    input  logic [lfu_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic [lfu_pkg::S_TUSER_W-1:0]   s_tuser,
    output logic [lfu_pkg::M_TDATA_W-1:0]   m_tdata,
    input  lfu_pkg::lfu_cmd_t               cmd,
    output lfu_pkg::lfu_status_t            status
);
    import lfu_pkg::*;

    localparam int unsigned IDX_W  = $clog2(CAPACITY);
    localparam int unsigned HELD_W = $clog2(CAPACITY + 1);
    localparam int unsigned CMP_W  = (HELD_W > CFG_W) ? HELD_W : CFG_W;
    localparam int unsigned LEVELS = $clog2(CAPACITY);
    localparam int unsigned NODES  = 1 << LEVELS;
    localparam int unsigned HALF   = NODES / 2;
    localparam int unsigned KEY_W  = COUNT_BITS + IDX_W;
    localparam int unsigned PAD_W  = M_TDATA_W - M_FIELDS_W;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [CMP_W-1:0] CAP_MAX = CMP_W'(CAPACITY);

    // configuration and occupancy
    logic [CFG_W-1:0]        cap_reg;
    logic [HELD_W-1:0]       held_reg;
    logic [CMP_W-1:0]        cap_ext, cap_eff;
    logic                    full;

    // captured request
    logic                    req_op_reg;
    logic [ADDRESS_BITS-1:0] req_tag_reg;

    // table
    logic [ADDRESS_BITS-1:0] tag_reg   [CAPACITY];
    logic [COUNT_BITS-1:0]   count_reg [CAPACITY];
    logic [IDX_W-1:0]        rank_reg  [CAPACITY];
    logic [CAPACITY-1:0]     held_mask;

    // lookup
    logic                    hit_any;
    logic [IDX_W-1:0]        hit_idx;
    logic                    hit_reg, evict_reg;
    logic [IDX_W-1:0]        hit_idx_reg;

    // min tree
    logic                    leaf_valid [NODES];
    logic [KEY_W-1:0]        leaf_key   [NODES];
    logic [IDX_W-1:0]        leaf_idx   [NODES];
    logic                    node_valid_reg [NODES];
    logic [KEY_W-1:0]        node_key_reg   [NODES];
    logic [IDX_W-1:0]        node_idx_reg   [NODES];
    logic                    step_valid [HALF];
    logic [KEY_W-1:0]        step_key   [HALF];
    logic [IDX_W-1:0]        step_idx   [HALF];

    // update
    logic                    write_new, age_all;
    logic [IDX_W-1:0]        victim, slot;
    logic [IDX_W-1:0]        old_rank;
    logic [COUNT_BITS-1:0]   hit_count;
    logic [SLOT_W-1:0]       out_slot;
    logic [ADDR_W-1:0]       out_ev_addr;
    logic [M_TDATA_W-1:0]    m_tdata_reg;

    // effective capacity, zero taken as one and clamped to the table size
    assign cap_ext = CMP_W'(cap_reg);
    always_comb begin
        if (cap_ext == '0) begin
            cap_eff = CMP_W'(1);
        end else if (cap_ext > CAP_MAX) begin
            cap_eff = CAP_MAX;
        end else begin
            cap_eff = cap_ext;
        end
    end
    assign full = (CMP_W'(held_reg) >= cap_eff);

    // entries below the fill level are live, tree leaves padded to a power of two
    for (genvar g = 0; g < NODES; g++) begin : g_leaf
        if (g < CAPACITY) begin : g_real
            assign held_mask[g]  = (HELD_W'(g) < held_reg);
            assign leaf_valid[g] = held_mask[g];
            assign leaf_key[g]   = {count_reg[g], ~rank_reg[g]};
        end else begin : g_pad
            assign leaf_valid[g] = 1'b0;
            assign leaf_key[g]   = '1;
        end
        assign leaf_idx[g] = IDX_W'(g);
    end

    // parallel tag compare, held tags are distinct
    always_comb begin
        hit_any = 1'b0;
        hit_idx = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (held_mask[i] && (tag_reg[i] == req_tag_reg)) begin
                hit_any = 1'b1;
                hit_idx = IDX_W'(i);
            end
        end
    end

    assign status.hit        = hit_any;
    assign status.need_evict = !hit_any && (req_op_reg == OP_ACCESS) && full;

    // one level of pairwise minimum: lowest count, then oldest rank
    always_comb begin
        for (int i = 0; i < HALF; i++) begin
            if (!node_valid_reg[2*i] ||
                (node_valid_reg[2*i+1] && (node_key_reg[2*i+1] < node_key_reg[2*i]))) begin
                step_key[i] = node_key_reg[2*i+1];
                step_idx[i] = node_idx_reg[2*i+1];
            end else begin
                step_key[i] = node_key_reg[2*i];
                step_idx[i] = node_idx_reg[2*i];
            end
            step_valid[i] = node_valid_reg[2*i] || node_valid_reg[2*i+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.lookup) begin
            for (int i = 0; i < NODES; i++) begin
                node_valid_reg[i] <= leaf_valid[i];
                node_key_reg[i]   <= leaf_key[i];
                node_idx_reg[i]   <= leaf_idx[i];
            end
        end else if (cmd.tree_step) begin
            for (int i = 0; i < HALF; i++) begin
                node_valid_reg[i] <= step_valid[i];
                node_key_reg[i]   <= step_key[i];
                node_idx_reg[i]   <= step_idx[i];
            end
        end
    end

    // request capture and lookup outcome
    always_ff @(posedge aclk) begin
        if (cmd.req_load) begin
            req_op_reg  <= s_tuser[0];
            req_tag_reg <= ADDRESS_BITS'(s_tdata[ADDR_W-1:0]);
        end
        if (cmd.lookup) begin
            hit_reg     <= hit_any;
            hit_idx_reg <= hit_idx;
            evict_reg   <= status.need_evict;
        end
    end

    // slot selection for the commit
    assign victim    = node_idx_reg[0];
    assign write_new = !hit_reg && (req_op_reg == OP_ACCESS);
    assign age_all   = write_new && !evict_reg;
    always_comb begin
        if (hit_reg) begin
            slot = hit_idx_reg;
        end else if (evict_reg) begin
            slot = victim;
        end else begin
            slot = IDX_W'(held_reg);
        end
    end
    assign old_rank  = rank_reg[slot];
    assign hit_count = count_reg[hit_idx_reg];

    // table update
    always_ff @(posedge aclk) begin
        if (cmd.commit && (hit_reg || write_new)) begin
            for (int i = 0; i < CAPACITY; i++) begin
                if (held_mask[i] && (age_all || (rank_reg[i] < old_rank))) begin
                    rank_reg[i] <= rank_reg[i] + 1'b1;
                end
            end
            rank_reg[slot] <= '0;
            if (hit_reg) begin
                if (hit_count != COUNT_MAX) begin
                    count_reg[slot] <= hit_count + 1'b1;
                end
            end else begin
                count_reg[slot] <= COUNT_BITS'(1);
                tag_reg[slot]   <= req_tag_reg;
            end
        end
    end

    // configuration register and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg  <= CAP_RESET;
            held_reg <= '0;
        end else begin
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
            if (cmd.commit && age_all) begin
                held_reg <= held_reg + 1'b1;
            end
        end
    end

    // result beat
    assign out_slot    = (hit_reg || write_new) ? SLOT_W'(slot) : '0;
    assign out_ev_addr = evict_reg ? ADDR_W'(tag_reg[victim]) : '0;
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            m_tdata_reg <= {{PAD_W{1'b0}}, out_ev_addr, evict_reg, out_slot, hit_reg};
        end
    end
    assign m_tdata = m_tdata_reg;

endmodule

[src/lfu_replacement_cache.sv]
// Top level of the lfu replacement cache. A fully associative table of
// CAPACITY address tags, each with a saturating use count. An access beat
// (tuser 0) looks up its address: a hit bumps the count, a miss fills a
// free entry while fewer than capacity_in_use are held and otherwise
// replaces the entry with the lowest count, the least recently filled or
// bumped one among equal counts. A touch beat (tuser 1) bumps on a hit
// only. Every request beat gives one result beat. One request is in work
// at a time: it passes the states idle, lookup and commit, and an access
// that evicts also passes a search step for each level of the pairwise
// minimum tree, which reduces one level per cycle. Commit waits for a free
// output register. The result sits in that register, so the next request
// is accepted while the last result waits. Write cfg_wr_en / cfg_wr_data
// only while the block is idle.
`include "lfu_replacement_cache_defines.svh"

module lfu_replacement_cache #(
    parameter int unsigned CAPACITY     = 16,
    parameter int unsigned ADDRESS_BITS = 32,
    parameter int unsigned COUNT_BITS   = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // capacity_in_use register
    input  logic                          cfg_wr_en,
    input  logic [lfu_pkg::CFG_W-1:0]     cfg_wr_data,
    // request beats
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [lfu_pkg::S_TDATA_W-1:0] s_tdata,   // [31:0] address
    input  logic [lfu_pkg::S_TUSER_W-1:0] s_tuser,   // [0] opcode
    // result beats
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [0] hit, [4:1] slot, [5] evicted, [37:6] evicted_address, [39:38] zero
    output logic [lfu_pkg::M_TDATA_W-1:0] m_tdata
);
    import lfu_pkg::*;

    localparam int unsigned LEVELS = $clog2(CAPACITY);

    lfu_cmd_t    cmd;
    lfu_status_t status;

    // sequencer
    lfu_ctrl #(
        .LEVELS (LEVELS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // table and victim search
    lfu_datapath #(
        .CAPACITY     (CAPACITY),
        .ADDRESS_BITS (ADDRESS_BITS),
        .COUNT_BITS   (COUNT_BITS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tdata     (m_tdata),
        .cmd         (cmd),
        .status      (status)
    );

    // one request in work at a time
    `LFU_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready, "request accepted while busy")
    // a result is only loaded into a free output register
    `LFU_ASSERT_NOW(a_commit_free, aclk, aresetn, cmd.commit, !m_tvalid || m_tready, "result register overwritten")
    // after a commit the result is shown and the input side is open again
    `LFU_ASSERT_NEXT(a_commit_done, aclk, aresetn, cmd.commit, m_tvalid && s_tready, "commit did not complete")

endmodule

[dv/lfu_replacement_cache_checker.sv]
// scoreboard of the lfu replacement cache: table prediction and result beat comparison
`timescale 1ns / 1ps

module lfu_replacement_cache_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [lfu_pkg::CFG_W-1:0]     cfg_wr_data,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [lfu_pkg::S_TDATA_W-1:0] s_tdata,   // [31:0] address
    input  logic [lfu_pkg::S_TUSER_W-1:0] s_tuser,   // [0] opcode
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    // [0] hit, [4:1] slot, [5] evicted, [37:6] evicted_address, [39:38] zero
    input  logic [lfu_pkg::M_TDATA_W-1:0] m_tdata,
    output int                            mismatches,
    output int                            in_flight,
    output int                            beats_checked,
    output int                            hits_seen,
    output int                            evicts_seen,
    output int                            touch_misses
);
    import lfu_pkg::*;

    localparam int unsigned ENTRIES   = 16;
    localparam int unsigned COUNT_W   = 16;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic              evicted;
        logic [ADDR_W-1:0] victim_tag;
    } outcome_t;

    // shadow copy of the table
    logic [ADDR_W-1:0]  tag_store [ENTRIES];
    logic [COUNT_W-1:0] use_count [ENTRIES];
    int unsigned        age_rank  [ENTRIES];
    int unsigned        entries_held;
    logic [CFG_W-1:0]   capacity_reg;

    outcome_t expected_outcomes [$];

    initial begin
        mismatches    = 0;
        in_flight     = 0;
        beats_checked = 0;
        hits_seen     = 0;
        evicts_seen   = 0;
        touch_misses  = 0;
        entries_held  = 0;
        capacity_reg  = CAP_RESET;
    end

    task automatic report_mismatch(string field, longint got, longint want);
        mismatches++;
        if (mismatches <= 40)
            $display("mismatch at %0t ns: %s got %0h expected %0h", $time, field, got, want);
    endtask

    // move one entry to the front of the recency order
    function automatic void make_recent(int unsigned idx);
        int unsigned prior;
        int unsigned i;
        prior = age_rank[idx];
        for (i = 0; i < entries_held; i++)
            if (age_rank[i] < prior)
                age_rank[i]++;
        age_rank[idx] = 0;
    endfunction

    // apply one request to the shadow table and return its result beat
    function automatic outcome_t predict_outcome(logic op, logic [ADDR_W-1:0] addr);
        outcome_t    res;
        int unsigned limit;
        int unsigned idx;
        int unsigned i;
        bit          found;
        res   = '0;
        found = 1'b0;
        idx   = 0;
        if (capacity_reg == 0)
            limit = 1;
        else if (capacity_reg > ENTRIES)
            limit = ENTRIES;
        else
            limit = capacity_reg;

        for (i = 0; i < entries_held; i++)
            if (!found && tag_store[i] == addr) begin
                found = 1'b1;
                idx   = i;
            end

        if (found) begin
            res.hit  = 1'b1;
            res.slot = idx[SLOT_W-1:0];
            if (use_count[idx] != COUNT_MAX)
                use_count[idx]++;
            make_recent(idx);
        end else if (op == OP_ACCESS) begin
            if (entries_held < limit) begin
                // free fill: everyone else ages by one
                idx = entries_held;
                for (i = 0; i < entries_held; i++)
                    age_rank[i]++;
                entries_held++;
                age_rank[idx] = 0;
            end else begin
                // lowest count wins, oldest among equal counts
                idx = 0;
                for (i = 1; i < entries_held; i++)
                    if (use_count[i] < use_count[idx] ||
                        (use_count[i] == use_count[idx] && age_rank[i] > age_rank[idx]))
                        idx = i;
                res.evicted    = 1'b1;
                res.victim_tag = tag_store[idx];
                make_recent(idx);
            end
            res.slot       = idx[SLOT_W-1:0];
            tag_store[idx] = addr;
            use_count[idx] = 1;
        end else begin
            touch_misses++;
        end
        return res;
    endfunction

    // watch both channels and the register port
    always @(posedge aclk) begin
        outcome_t got;
        outcome_t want;
        if (!aresetn) begin
            entries_held = 0;
            capacity_reg = CAP_RESET;
            expected_outcomes.delete();
        end else begin
            if (cfg_wr_en)
                capacity_reg = cfg_wr_data;

            if (m_tvalid && m_tready) begin
                got.hit        = m_tdata[0];
                got.slot       = m_tdata[4:1];
                got.evicted    = m_tdata[5];
                got.victim_tag = m_tdata[37:6];
                if (expected_outcomes.size() == 0) begin
                    report_mismatch("unexpected result beat", m_tdata, 0);
                end else begin
                    want = expected_outcomes.pop_front();
                    beats_checked++;
                    if (want.hit)
                        hits_seen++;
                    if (want.evicted)
                        evicts_seen++;
                    if (got.hit !== want.hit)
                        report_mismatch("hit", got.hit, want.hit);
                    if (got.slot !== want.slot)
                        report_mismatch("slot", got.slot, want.slot);
                    if (got.evicted !== want.evicted)
                        report_mismatch("evicted", got.evicted, want.evicted);
                    if (got.victim_tag !== want.victim_tag)
                        report_mismatch("evicted_address", got.victim_tag, want.victim_tag);
                end
            end

            if (s_tvalid && s_tready)
                expected_outcomes.push_back(predict_outcome(s_tuser[0], s_tdata));
        end
        in_flight = expected_outcomes.size();
    end

endmodule

[dv/lfu_replacement_cache_tb.sv]
// testbench top of the lfu replacement cache: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module lfu_replacement_cache_tb;
    import lfu_pkg::*;

    localparam int unsigned POOL_MAX = 20;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   cfg_wr_en;
    logic [CFG_W-1:0]       cfg_wr_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;    // [31:0] address
    logic [S_TUSER_W-1:0]   s_tuser;    // [0] opcode
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // [0] hit, [4:1] slot, [5] evicted, [37:6] evicted_address, [39:38] zero
    logic [M_TDATA_W-1:0]   m_tdata;

    int          mismatches;
    int          in_flight;
    int          beats_checked;
    int          hits_seen;
    int          evicts_seen;
    int          touch_misses;

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned holds_asked    = 0;
    int unsigned holds_taken    = 0;
    int unsigned hold_left      = 0;
    int unsigned settings_used  = 0;

    logic [ADDR_W-1:0] addr_pool [POOL_MAX];

    always #5 aclk = ~aclk;

    lfu_replacement_cache u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    lfu_replacement_cache_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .mismatches    (mismatches),
        .in_flight     (in_flight),
        .beats_checked (beats_checked),
        .hits_seen     (hits_seen),
        .evicts_seen   (evicts_seen),
        .touch_misses  (touch_misses)
    );

    // result side: random stalls, plus a long hold-off when one is asked for
    always @(posedge aclk) begin
        if (holds_taken != holds_asked) begin
            holds_taken = holds_asked;
            hold_left   = 150;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // one request beat, preceded by random idle cycles
    task automatic send_request(logic op, logic [ADDR_W-1:0] addr);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid   <= 1'b1;
        s_tdata    <= addr;
        s_tuser[0] <= op;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    // register write once the table has drained
    task automatic set_capacity(logic [CFG_W-1:0] value);
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (in_flight != 0)
            @(negedge aclk);
        repeat (12) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        settings_used++;
    endtask

    // random requests mostly drawn from a pool sized a little above capacity
    task automatic run_phase(logic [CFG_W-1:0] cap, int unsigned idle_pct,
                             int unsigned stall_pct, int unsigned n_items,
                             int unsigned hold_at);
        int unsigned pool_size;
        int unsigned i;
        logic        op;
        logic [ADDR_W-1:0] addr;
        set_capacity(cap);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        if (cap == 0)
            pool_size = 5;
        else if (cap > 16)
            pool_size = POOL_MAX;
        else
            pool_size = cap + 4;
        for (i = 0; i < POOL_MAX; i++)
            addr_pool[i] = $urandom;
        if ($urandom_range(1))
            addr_pool[0] = '0;
        if ($urandom_range(1))
            addr_pool[1] = '1;
        for (i = 0; i < n_items; i++) begin
            if (hold_at != 0 && i == hold_at)
                holds_asked++;
            op   = ($urandom_range(99) < 30) ? OP_TOUCH : OP_ACCESS;
            addr = ($urandom_range(99) < 15) ? $urandom
                                             : addr_pool[$urandom_range(pool_size - 1)];
            send_request(op, addr);
        end
    endtask

    initial begin
        int unsigned i;
        int unsigned drain;
        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tuser     <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part at the reset capacity
        send_request(OP_TOUCH, 32'h1234_5678);      // touch miss on an empty table
        send_request(OP_ACCESS, 32'h0000_0000);
        send_request(OP_ACCESS, 32'hFFFF_FFFF);
        send_request(OP_ACCESS, 32'hAAAA_AAAA);
        send_request(OP_ACCESS, 32'h5555_5555);
        send_request(OP_ACCESS, 32'h0000_0000);     // access hit
        send_request(OP_TOUCH, 32'hFFFF_FFFF);      // touch hit
        send_request(OP_TOUCH, 32'h0BAD_F00D);      // touch miss, table not empty
        for (i = 0; i < 12; i++)
            send_request(OP_ACCESS, 32'h0000_0010 + i);
        send_request(OP_ACCESS, 32'hDEAD_BEEF);     // full: evicts oldest count-one entry
        send_request(OP_ACCESS, 32'hAAAA_AAAA);     // evicted tag comes back
        send_request(OP_TOUCH, 32'hDEAD_BEEF);

        // capacity below the entries held, then the extremes of the register
        run_phase(5'd2,  0,  0,  150, 0);
        run_phase(5'd0,  66, 0,  150, 0);
        run_phase(5'd31, 0,  66, 200, 0);
        run_phase(5'd1,  30, 30, 150, 0);
        run_phase(5'd16, 30, 30, 250, 100);
        run_phase(5'd8,  0,  0,  150, 0);
        run_phase(5'd17, 66, 0,  150, 0);
        run_phase(5'd5,  0,  66, 150, 0);

        // one tag bumped many times, then misses and hits around it
        set_capacity(5'd2);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_request(OP_ACCESS, 32'h5A5A_0001);
        for (i = 0; i < 20; i++)
            send_request(OP_TOUCH, 32'h5A5A_0001);
        for (i = 0; i < 40; i++)
            send_request(($urandom_range(3) == 0) ? OP_TOUCH : OP_ACCESS,
                         ($urandom_range(3) == 0) ? 32'h5A5A_0001 : $urandom);

        // drain and decide
        s_tvalid <= 1'b0;
        @(negedge aclk);
        for (drain = 0; drain < 20000 && in_flight != 0; drain++)
            @(negedge aclk);
        repeat (20) @(posedge aclk);
        @(negedge aclk);
        $display("covered %0d result beats over %0d capacity settings plus the reset value",
                 beats_checked, settings_used);
        $display("of them %0d hits, %0d evictions, %0d touch misses; %0d mismatches",
                 hits_seen, evicts_seen, touch_misses, mismatches);
        if (mismatches == 0 && in_flight == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // hard stop
    initial begin
        #15_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

[lfu_replacement_cache.f]
+incdir+src
src/lfu_pkg.sv
src/lfu_ctrl.sv
src/lfu_datapath.sv
src/lfu_replacement_cache.sv
dv/lfu_replacement_cache_checker.sv
dv/lfu_replacement_cache_tb.sv
